// ----- src/rwct_pkg.sv -----
// ----------------------------------------------------------------------------
// rwct_pkg
// Shared types and constants for the row reservation table with wrapped
// conflict scan.
// ----------------------------------------------------------------------------
`default_nettype none

package rwct_pkg;

  // Table geometry
  localparam int MAX_PARTITIONS = 16;
  localparam int ROW_SLOTS      = MAX_PARTITIONS + 1;
  localparam int MASK_W         = 16;
  localparam int ROW_W          = 5;
  localparam int PART_W         = 5;
  localparam int CNT_W          = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // One table row as stored in memory
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] bits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Engine sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RELEASE,
    ST_DONE
  } state_t;

  // Result handed from the engine to the output stage
  typedef struct packed {
    logic             no_free_row;
    logic             head_advanced;
    logic [ROW_W-1:0] head_row;
    logic             row_active;
    logic [ROW_W-1:0] row;
  } result_t;

  // Partition count clamped to 1..MAX_PARTITIONS
  function automatic logic [PART_W-1:0] eff_parts(input logic [PART_W-1:0] p);
    logic [PART_W-1:0] r;
    r = p;
    if (p == '0) r = PART_W'(1);
    if (p > PART_W'(MAX_PARTITIONS)) r = PART_W'(MAX_PARTITIONS);
    return r;
  endfunction

  // Ones in the bit positions below the partition count
  function automatic logic [MASK_W-1:0] part_mask(input logic [PART_W-1:0] p);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (PART_W'(i) < p);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- src/rwct_ram.sv -----
// ----------------------------------------------------------------------------
// rwct_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rwct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rwct_engine.sv -----
// ----------------------------------------------------------------------------
// rwct_engine
// Sequencer: holds head row, partition count and row valid bits, walks the
// table memory one row a cycle and writes the updated row back.
// ----------------------------------------------------------------------------
`default_nettype none

module rwct_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [rwct_pkg::PART_W-1:0]      cfg_wdata,
  // request side
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic                             req_kind,
  input  wire logic [rwct_pkg::MASK_W-1:0]      req_mask,
  input  wire logic [rwct_pkg::ROW_W-1:0]       req_row,
  // result side
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output rwct_pkg::result_t                     res,
  // table memory
  output logic                                  mem_we,
  output logic [rwct_pkg::ROW_W-1:0]            mem_waddr,
  output rwct_pkg::entry_t                      mem_wdata,
  output logic                                  mem_re,
  output logic [rwct_pkg::ROW_W-1:0]            mem_raddr,
  input  wire rwct_pkg::entry_t                 mem_rdata
);

  import rwct_pkg::*;

  // control state
  state_t            state, state_next;
  logic [PART_W-1:0] parts, parts_next;
  logic [ROW_W-1:0]  head, head_next;
  logic [ROW_SLOTS-1:0] row_valid, row_valid_next;

  // per-request payload
  logic [MASK_W-1:0] mask, mask_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ROW_W-1:0]  scan_cnt, scan_cnt_next;
  result_t           result, result_next;

  // scratch
  logic [PART_W-1:0] pe, pe_cfg;
  logic [ROW_W-1:0]  rows, rows_cfg;
  logic [ROW_W-1:0]  head_c;
  logic [ROW_W-1:0]  row_wrap;
  logic [ROW_W-1:0]  rel_wrap;
  entry_t            ent;
  entry_t            upd;
  logic              hit;

  assign pe       = eff_parts(parts);
  assign rows     = ROW_W'(pe) + ROW_W'(1);
  assign pe_cfg   = eff_parts(cfg_wdata);
  assign rows_cfg = ROW_W'(pe_cfg) + ROW_W'(1);
  assign head_c   = (head >= rows) ? '0 : head;

  // stored row, or zero if never written since reset
  assign ent      = row_valid[cur_row] ? mem_rdata : '0;
  assign hit      = (ent.bits & mask) == '0;
  assign row_wrap = (cur_row + ROW_W'(1) >= rows) ? '0 : cur_row + ROW_W'(1);
  assign rel_wrap = row_wrap;

  assign req_ready = (state == ST_IDLE) && !rst;
  assign res_valid = (state == ST_DONE);
  assign res       = result;

  // next state and datapath
  always_comb begin
    state_next     = state;
    parts_next     = parts;
    head_next      = head;
    row_valid_next = row_valid;
    mask_next      = mask;
    cur_row_next   = cur_row;
    scan_cnt_next  = scan_cnt;
    result_next    = result;
    mem_we         = 1'b0;
    mem_waddr      = cur_row;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = cur_row;
    upd            = ent;

    case (state)
      ST_IDLE: begin
        // register write, head pulled back if it falls outside the table
        if (cfg_we) begin
          parts_next = cfg_wdata;
          if (head >= rows_cfg) head_next = '0;
        end
        if (req_valid) begin
          head_next     = head_c;
          mask_next     = req_mask & part_mask(pe);
          scan_cnt_next = '0;
          if (req_kind == KIND_REQUEST) begin
            cur_row_next = head_c;
            mem_re       = 1'b1;
            mem_raddr    = head_c;
            state_next   = ST_SCAN;
          end else if (req_row < rows) begin
            cur_row_next = req_row;
            mem_re       = 1'b1;
            mem_raddr    = req_row;
            state_next   = ST_RELEASE;
          end else begin
            // release outside the table: report only
            result_next.row           = req_row;
            result_next.row_active    = (req_row == head_c);
            result_next.head_row      = head_c;
            result_next.head_advanced = 1'b0;
            result_next.no_free_row   = 1'b0;
            state_next                = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          // grant: merge mask bits, bump count with saturation
          upd.bits = ent.bits | mask;
          if (ent.count != COUNT_MAX) upd.count = ent.count + CNT_W'(1);
          mem_we                    = 1'b1;
          mem_waddr                 = cur_row;
          mem_wdata                 = upd;
          row_valid_next[cur_row]   = 1'b1;
          result_next.row           = cur_row;
          result_next.row_active    = (cur_row == head);
          result_next.head_row      = head;
          result_next.head_advanced = 1'b0;
          result_next.no_free_row   = 1'b0;
          state_next                = ST_DONE;
        end else if (scan_cnt == rows - ROW_W'(1)) begin
          // every row in use conflicts
          result_next.row           = '0;
          result_next.row_active    = 1'b0;
          result_next.head_row      = head;
          result_next.head_advanced = 1'b0;
          result_next.no_free_row   = 1'b1;
          state_next                = ST_DONE;
        end else begin
          // fetch the following row, wrapping to row zero
          mem_re        = 1'b1;
          mem_raddr     = row_wrap;
          cur_row_next  = row_wrap;
          scan_cnt_next = scan_cnt + ROW_W'(1);
        end
      end

      ST_RELEASE: begin
        upd.bits                  = ent.bits & ~mask;
        result_next.head_advanced = 1'b0;
        if (ent.count != '0) begin
          upd.count = ent.count - CNT_W'(1);
          if (ent.count == CNT_W'(1)) begin
            head_next                 = rel_wrap;
            result_next.head_advanced = 1'b1;
          end
        end
        mem_we                  = 1'b1;
        mem_waddr               = cur_row;
        mem_wdata               = upd;
        row_valid_next[cur_row] = 1'b1;
        result_next.row         = cur_row;
        result_next.row_active  = (cur_row == head_next);
        result_next.head_row    = head_next;
        result_next.no_free_row = 1'b0;
        state_next              = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      parts     <= PART_W'(MAX_PARTITIONS);
      head      <= '0;
      row_valid <= '0;
    end else begin
      state     <= state_next;
      parts     <= parts_next;
      head      <= head_next;
      row_valid <= row_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mask     <= mask_next;
    cur_row  <= cur_row_next;
    scan_cnt <= scan_cnt_next;
    result   <= result_next;
  end

endmodule

`default_nettype wire

// ----- src/row_wrap_conflict_reservation_table_core.sv -----
// ----------------------------------------------------------------------------
// row_wrap_conflict_reservation_table_core
// Reservation table of rows by partitions: a request takes the first row,
// from the head and wrapping, whose reserved bits miss its conflict mask;
// a release clears bits in a row and moves the head when the row empties.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / data fields (low bit up)             other
//  s_axis    in   conflict_mask[15:0], release_row[20:16]      tuser = kind
//  m_axis    out  row[4:0], row_active[5], head_row[10:6],
//                 head_advanced[11], no_free_row[12]
//  cfg       in   cfg_wdata = partitions_in_use                cfg_we
//
//  A request examines n rows, n = 1 .. partitions + 1, in a one-row-per-cycle
//  walk over the table RAM; a release reads its row and writes it back, or
//  only reports when its row lies outside the table.
//  One item is in flight at a time; the next is taken once its result has
//  moved into the output register, which holds it while m_axis_tready is low.
//  rst is synchronous; row contents read as zero after reset through per-row
//  valid flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module row_wrap_conflict_reservation_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,      // partitions_in_use
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // conflict_mask[15:0], release_row[20:16]
  input  wire logic        s_axis_tuser,   // kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // row, row_active, head_row,
                                           // head_advanced, no_free_row
);

  import rwct_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic    mem_we;
  logic [ROW_W-1:0] mem_waddr;
  entry_t  mem_wdata;
  logic    mem_re;
  logic [ROW_W-1:0] mem_raddr;
  entry_t  mem_rdata;

  // sequencer
  rwct_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_kind  (s_axis_tuser),
    .req_mask  (s_axis_tdata[MASK_W-1:0]),
    .req_row   (s_axis_tdata[MASK_W+ROW_W-1:MASK_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // table storage: reserved bits and count per row
  rwct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROW_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {3'b000, res};
    end
  end

endmodule

`default_nettype wire

// ----- tb/row_wrap_conflict_reservation_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// row_wrap_conflict_reservation_table_core_tb
// Self-checking bench for the row reservation table. A short table of
// hand-picked requests and releases runs first. Random traffic follows across
// several partition settings, mostly grants that are later handed back with
// their own masks. Every result is checked against an in-bench model of the
// table, while both stream sides stall at random.
// ----------------------------------------------------------------------------
module row_wrap_conflict_reservation_table_core_tb;
  import rwct_pkg::*;

  // directed table step kinds
  typedef enum logic [1:0] {
    OP_REQUEST,
    OP_RELEASE,
    OP_CONFIG
  } step_op_t;

  typedef struct {
    step_op_t         op;
    logic [15:0]      cmask;
    logic [4:0]       arg;     // release row, or partition count for OP_CONFIG
    bit               typed;   // use the typed-in result below
    result_t          want;
  } step_t;

  // row granted earlier and the mask it was granted with
  typedef struct {
    logic [4:0]  row;
    logic [15:0] cmask;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;

  // model of the table
  logic [15:0] row_bits [0:ROW_SLOTS-1];
  logic [4:0]  row_cnt  [0:ROW_SLOTS-1];
  logic [4:0]  head;
  logic [4:0]  parts_reg;

  result_t     pending_results[$];
  grant_t      grant_q[$];
  step_t       steps[$];
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          fails = 0;
  int          n_req = 0, n_rel = 0, n_nofree = 0, n_adv = 0, n_sat = 0, n_cfg = 0;
  result_t     want_r, got_r;

  row_wrap_conflict_reservation_table_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // watchdog
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // partition count clamped to 1..16
  function automatic int live_parts();
    int p;
    p = parts_reg;
    if (p < 1) p = 1;
    if (p > MAX_PARTITIONS) p = MAX_PARTITIONS;
    return p;
  endfunction

  // one step of the table: updates the model, returns the result
  function automatic result_t reserve_predict(logic kind, logic [15:0] cmask,
                                              logic [4:0] rel);
    int      rows, r;
    bit      found;
    logic [15:0] m;
    result_t res;
    rows  = live_parts() + 1;
    m     = cmask & 16'((32'h1 << live_parts()) - 1);
    res   = '0;
    found = 1'b0;
    if (head >= rows) head = '0;
    if (kind == KIND_REQUEST) begin
      r = head;
      for (int i = 0; i < rows; i++) begin
        if ((row_bits[r] & m) == '0) begin
          found = 1'b1;
          break;
        end
        r = (r + 1 >= rows) ? 0 : r + 1;
      end
      if (found) begin
        row_bits[r] |= m;
        if (row_cnt[r] != COUNT_MAX) row_cnt[r]++;
        else n_sat++;
        res.row        = 5'(r);
        res.row_active = (5'(r) == head);
      end else begin
        res.no_free_row = 1'b1;
      end
    end else begin
      res.row = rel;
      if (rel < rows) begin
        row_bits[rel] &= ~m;
        if (row_cnt[rel] != '0) begin
          row_cnt[rel]--;
          if (row_cnt[rel] == '0) begin
            head = (rel + 1 >= rows) ? 5'd0 : rel + 5'd1;
            res.head_advanced = 1'b1;
          end
        end
      end
      res.row_active = (rel == head);
    end
    res.head_row = head;
    return res;
  endfunction

  // hold off new requests until every result is back and the block is idle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // partition count write, only while idle
  task automatic write_parts(input logic [4:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    parts_reg = v;
    if (head >= live_parts() + 1) head = '0;
    n_cfg++;
  endtask

  // send one request and queue its expected result
  task automatic put_item(input logic kind, input logic [15:0] cmask,
                          input logic [4:0] rel, input bit typed = 1'b0,
                          input result_t want = '0);
    result_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, rel, cmask};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = reserve_predict(kind, cmask, rel);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    if (kind == KIND_REQUEST) begin
      n_req++;
      if (pred.no_free_row) n_nofree++;
      else grant_q.insert(grant_q.size(), '{row: pred.row, cmask: cmask});
    end else begin
      n_rel++;
      if (pred.head_advanced) n_adv++;
    end
  endtask

  task automatic add_step(input step_op_t op, input logic [15:0] cmask,
                          input logic [4:0] arg, input bit typed = 1'b0,
                          input logic [4:0] row = '0, input bit act = 1'b0,
                          input logic [4:0] hd = '0, input bit adv = 1'b0,
                          input bit nf = 1'b0);
    step_t s;
    s.op                 = op;
    s.cmask              = cmask;
    s.arg                = arg;
    s.typed              = typed;
    s.want               = '0;
    s.want.row           = row;
    s.want.row_active    = act;
    s.want.head_row      = hd;
    s.want.head_advanced = adv;
    s.want.no_free_row   = nf;
    steps.insert(steps.size(), s);
  endtask

  task automatic check_field(input string name, input int unsigned e,
                             input int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endtask

  // result stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result %h with nothing outstanding", m_axis_tdata);
        fails++;
      end else begin
        want_r = pending_results.pop_front();
        got_r  = result_t'(m_axis_tdata[12:0]);
        check_field("row", want_r.row, got_r.row);
        check_field("row_active", want_r.row_active, got_r.row_active);
        check_field("head_row", want_r.head_row, got_r.head_row);
        check_field("head_advanced", want_r.head_advanced, got_r.head_advanced);
        check_field("no_free_row", want_r.no_free_row, got_r.no_free_row);
        check_field("pad", 0, m_axis_tdata[15:13]);
      end
    end
  end

  // stimulus
  initial begin
    int          pv, p, idx, sel;
    logic [15:0] m;
    grant_t      g;
    step_t       s;
    for (int i = 0; i < ROW_SLOTS; i++) begin
      row_bits[i] = '0;
      row_cnt[i]  = '0;
    end
    head      = '0;
    parts_reg = 5'd16;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, partition count 16 from reset
    add_step(OP_REQUEST, 16'h0001, 5'd0,  1, 5'd0,  1, 5'd0, 0, 0);
    add_step(OP_REQUEST, 16'h0003, 5'd0,  1, 5'd1,  0, 5'd0, 0, 0);
    add_step(OP_REQUEST, 16'h0000, 5'd0,  1, 5'd0,  1, 5'd0, 0, 0); // empty mask
    add_step(OP_REQUEST, 16'hFFFF, 5'd0,  1, 5'd2,  0, 5'd0, 0, 0);
    add_step(OP_RELEASE, 16'hFFFF, 5'd31, 1, 5'd31, 0, 5'd0, 0, 0); // row out of range
    add_step(OP_RELEASE, 16'h8000, 5'd16, 1, 5'd16, 0, 5'd0, 0, 0); // empty row
    add_step(OP_RELEASE, 16'hFFFF, 5'd2,  1, 5'd2,  0, 5'd3, 1, 0); // head moves on
    add_step(OP_RELEASE, 16'h0001, 5'd0);
    add_step(OP_REQUEST, 16'h8000, 5'd0);
    add_step(OP_CONFIG,  16'h0000, 5'd1);                            // head falls back to 0
    add_step(OP_REQUEST, 16'h0002, 5'd0);                            // bits above partitions
    add_step(OP_REQUEST, 16'h0001, 5'd0);
    add_step(OP_REQUEST, 16'h0001, 5'd0);                            // no free row
    add_step(OP_RELEASE, 16'hFFFF, 5'd1);
    add_step(OP_CONFIG,  16'h0000, 5'd0);                            // zero acts as one
    add_step(OP_REQUEST, 16'hFFFF, 5'd31);
    add_step(OP_CONFIG,  16'h0000, 5'd31);                           // clamps to 16
    add_step(OP_REQUEST, 16'hAAAA, 5'd0);
    add_step(OP_RELEASE, 16'hFFFF, 5'd16);
    add_step(OP_RELEASE, 16'hFFFF, 5'd17);
    add_step(OP_CONFIG,  16'h0000, 5'd16);
    add_step(OP_REQUEST, 16'h5555, 5'd0);
    add_step(OP_RELEASE, 16'h8000, 5'd3);
    foreach (steps[i]) begin
      s = steps[i];
      case (s.op)
        OP_CONFIG:  write_parts(s.arg);
        OP_REQUEST: put_item(KIND_REQUEST, s.cmask, s.arg, s.typed, s.want);
        default:    put_item(KIND_RELEASE, s.cmask, s.arg, s.typed, s.want);
      endcase
    end

    // random phases, one partition setting each
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       pv = 1;
        1:       pv = 0;
        2:       pv = 31;
        3:       pv = 17;
        4:       pv = 2;
        5:       pv = 5;
        11:      pv = 16;
        default: pv = $urandom_range(0, 31);
      endcase
      if (ph == 11) quiet = 1'b1;
      write_parts(5'(pv));
      grant_q.delete();
      for (int k = 0; k < 155; k++) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        sel = $urandom_range(0, 99);
        if (ph == 2 && k < 40) begin
          // pile empty-mask grants onto the head row past its count limit
          put_item(KIND_REQUEST, 16'h0000, 5'($urandom));
        end else if (grant_q.size() != 0 && sel < 45) begin
          idx = $urandom_range(0, grant_q.size() - 1);
          g   = grant_q[idx];
          grant_q.delete(idx);
          m = ($urandom_range(0, 9) == 0) ? 16'($urandom) : g.cmask;
          put_item(KIND_RELEASE, m, g.row);
        end else if (sel < 85) begin
          // own partition plus its neighbors
          p = $urandom_range(0, live_parts() - 1);
          m = 16'h1 << p;
          if (p > 0) m |= 16'h1 << (p - 1);
          if (p + 1 < live_parts()) m |= 16'h1 << (p + 1);
          put_item(KIND_REQUEST, m, 5'($urandom));
        end else begin
          m = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
          put_item(1'($urandom), m, 5'($urandom));
        end
      end
    end

    drain_results();
    $display("Run: %0d requests (%0d without a free row), %0d releases (%0d moved the head)",
             n_req, n_nofree, n_rel, n_adv);
    $display("     %0d partition count writes, %0d grants on a row at its count limit",
             n_cfg, n_sat);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
